// File: sv/windowed_sample_averager_unit_macros.svh
// Assertion macros shared by the averager checker.
`ifndef WINDOWED_SAMPLE_AVERAGER_UNIT_MACROS_SVH
`define WINDOWED_SAMPLE_AVERAGER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/wsa_pkg.sv
// Shared types and constants of the windowed sample averager.
`default_nettype none

package wsa_pkg;

  // Field widths of the channels and the window register
  localparam int MODE_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 16;
  localparam int WIN_W    = 6;
  localparam int WIN_MAX  = 63;

  localparam logic [WIN_W-1:0] WIN_RESET = 6'd4;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_BLOCK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SLIDE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR_ALT = 2'd3;

  // Register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_WINDOW = 1'b0;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic sum_en;
    logic div_init;
    logic div_en;
    logic load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;
    logic sum_done;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/wsa_if.sv
// Channel interfaces: sample words in, mean words out.
`default_nettype none

interface wsa_sample_if;
  logic                        valid;
  logic                        ready;
  logic [wsa_pkg::MODE_W-1:0]   mode;
  logic [wsa_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, mode, sample, input ready);
  modport sink   (input valid, mode, sample, output ready);
endinterface

interface wsa_mean_if;
  logic                      valid;
  logic                      ready;
  logic [wsa_pkg::MEAN_W-1:0] mean;

  modport source (output valid, mean, input ready);
  modport sink   (input valid, mean, output ready);
endinterface

`default_nettype wire

// File: sv/wsa_regs.sv
// APB register block holding the window size.
`default_nettype none

module wsa_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [wsa_pkg::PDATA_W-1:0]  pwdata,
  output logic [wsa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [wsa_pkg::WIN_W-1:0]    window_size
);

  logic hit;

  // Decode the register index from the word address
  assign hit    = (paddr[wsa_pkg::PADDR_W-1:2] == wsa_pkg::REG_WINDOW);
  assign pready = 1'b1;
  assign prdata = hit ? wsa_pkg::PDATA_W'(window_size) : '0;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= wsa_pkg::WIN_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      window_size <= pwdata[wsa_pkg::WIN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: sv/wsa_ctrl.sv
// Sequencer: accept, sum the window, divide, hand the mean to the output.
`default_nettype none

module wsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wsa_pkg::sts_t sts,
  output wsa_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Commands per state
  always_comb begin
    cmd          = '0;
    cmd.take     = (state == S_IDLE) && in_valid;
    cmd.sum_en   = (state == S_SUM);
    cmd.div_init = (state == S_SUM) && sts.sum_done;
    cmd.div_en   = (state == S_DIV) && !sts.div_done;
    cmd.load     = (state == S_DIV) && sts.div_done && !sts.out_busy;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && sts.emit) state_next = S_SUM;
      end
      S_SUM: begin
        if (sts.sum_done) state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done && !sts.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/wsa_datapath.sv
// Sample store, window accumulator, serial divider and output register.
`default_nettype none

module wsa_datapath #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [wsa_pkg::WIN_W-1:0]    window_size,
  input  logic [wsa_pkg::MODE_W-1:0]   mode,
  input  logic [wsa_pkg::SAMPLE_W-1:0] sample,
  input  wsa_pkg::cmd_t                cmd,
  output wsa_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wsa_pkg::MEAN_W-1:0]   mean
);

  // The window register cannot exceed WIN_MAX, so deeper entries are never used
  localparam int DEPTH  = (MAX_WINDOW < wsa_pkg::WIN_MAX) ? MAX_WINDOW : wsa_pkg::WIN_MAX;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       filled;

  logic [CNT_W-1:0]       n;
  logic [CNT_W-1:0]       fill_index;
  logic [CNT_W-1:0]       idx_w;
  logic [CNT_W-1:0]       idx_inc;
  logic                   is_clear;
  logic                   is_slide;

  logic [CNT_W-1:0]       rd_addr;
  logic                   rd_pend;
  logic                   rd_hit;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SUM_W-1:0]       acc;

  logic [SUM_W-1:0]       quo;
  logic [CNT_W-1:0]       rem;
  logic [DCNT_W-1:0]      dcnt;
  logic [CNT_W:0]         shl;
  logic                   fits;

  // Clamp the window to 1..DEPTH
  always_comb begin
    if (window_size == '0) begin
      n = CNT_W'(1);
    end else if (window_size > wsa_pkg::WIN_W'(DEPTH)) begin
      n = CNT_W'(DEPTH);
    end else begin
      n = CNT_W'(window_size);
    end
  end

  // Wrap the write index, decode the mode
  assign idx_w    = (fill_index >= n) ? '0 : fill_index;
  assign idx_inc  = idx_w + CNT_W'(1);
  assign is_clear = (mode == wsa_pkg::MODE_CLEAR) || (mode == wsa_pkg::MODE_CLEAR_ALT);
  assign is_slide = (mode == wsa_pkg::MODE_SLIDE);

  // One restoring division step
  assign shl  = {rem, quo[SUM_W-1]};
  assign fits = (shl >= {1'b0, n});

  always_comb begin
    sts          = '0;
    sts.emit     = !is_clear && (is_slide || (idx_inc == n));
    sts.sum_done = (rd_addr == n) && !rd_pend;
    sts.div_done = (dcnt == DCNT_W'(SUM_W));
    sts.out_busy = out_valid && !out_ready;
  end

  // Control state: index, entry valid bits, read pipe, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_index <= '0;
      filled     <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (is_clear) begin
          fill_index <= '0;
          filled     <= '0;
        end else begin
          fill_index                  <= idx_inc;
          filled[idx_w[ADDR_W-1:0]] <= 1'b1;
        end
      end
      if (cmd.take) begin
        rd_pend <= 1'b0;
      end else if (cmd.sum_en) begin
        rd_pend <= (rd_addr < n);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Store the new sample
  always_ff @(posedge clk) begin
    if (cmd.take && !is_clear) begin
      mem[idx_w[ADDR_W-1:0]] <= SAMPLE_BITS'(sample);
    end
  end

  // Walk the window one entry a cycle; unwritten entries count as zero
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_addr <= '0;
      acc     <= '0;
    end else if (cmd.sum_en) begin
      if (rd_addr < n) begin
        rd_data <= mem[rd_addr[ADDR_W-1:0]];
        rd_hit  <= filled[rd_addr[ADDR_W-1:0]];
        rd_addr <= rd_addr + CNT_W'(1);
      end
      if (rd_pend && rd_hit) begin
        acc <= acc + SUM_W'(rd_data);
      end
    end
  end

  // Divide the sum by the window, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo  <= acc;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_en) begin
      rem  <= fits ? CNT_W'(shl - {1'b0, n}) : shl[CNT_W-1:0];
      quo  <= {quo[SUM_W-2:0], fits};
      dcnt <= dcnt + DCNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mean <= wsa_pkg::MEAN_W'(quo);
    end
  end

endmodule

`default_nettype wire

// File: sv/windowed_sample_averager_unit.sv
// Top level of the windowed sample averager.
//
// Usage: sample words (mode, sample) enter on the samples channel, mean words
// leave on the means channel; both use valid/ready and move a word when both
// are high. The window size (1..min(MAX_WINDOW,63), reset 4; 0 acts as 1)
// is written over the APB port at byte address 0 while the block is idle.
// Block mode stores the sample and emits the truncated window mean when the
// write index reaches the window size; sliding mode stores and emits every
// time; clear mode empties the store and the index and emits nothing.
// Timing: a word that emits nothing leaves the block idle. A word that emits
// is summed by reading the window from the store through its single read
// port, then the serial divider resolves one quotient bit per cycle, and the
// mean is loaded into the output register. One word is worked at a time.
// Reset empties the store and index, drops the output and sets window 4.
// A stalled receiver holds the mean in the output register; the next word is
// still accepted, and its quotient waits until the register frees up.
`default_nettype none

module windowed_sample_averager_unit #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  wsa_sample_if.sink                  samples,
  wsa_mean_if.source                  means,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsa_pkg::PADDR_W-1:0] paddr,
  input  logic [wsa_pkg::PDATA_W-1:0] pwdata,
  output logic [wsa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [wsa_pkg::WIN_W-1:0] window_size;
  wsa_pkg::cmd_t             cmd;
  wsa_pkg::sts_t             sts;

  wsa_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_size (window_size)
  );

  wsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wsa_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .window_size (window_size),
    .mode        (samples.mode),
    .sample      (samples.sample),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (means.valid),
    .out_ready   (means.ready),
    .mean        (means.mean)
  );

endmodule

`default_nettype wire

// File: sv/wsa_checker.sv
// Port-level checks of the averager, bound to the top level.
`default_nettype none
`include "windowed_sample_averager_unit_macros.svh"

module wsa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [wsa_pkg::MODE_W-1:0]  in_mode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wsa_pkg::MEAN_W-1:0]  out_mean
);

  // A sliding word always emits, so the block must go busy
  `WSA_ASSERT_NEXT(a_slide_busy, in_valid && in_ready && in_mode == wsa_pkg::MODE_SLIDE, !in_ready, "sliding word did not start a sum")

  // A clear word finishes at once
  `WSA_ASSERT_NEXT(a_clear_idle, in_valid && in_ready && (in_mode == wsa_pkg::MODE_CLEAR || in_mode == wsa_pkg::MODE_CLEAR_ALT), in_ready, "clear word left the block busy")

  // A stalled mean holds
  `WSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mean), "stalled mean changed")

  // A new mean only appears at the end of a busy phase
  `WSA_ASSERT_NOW(a_out_from_busy, $rose(out_valid), !$past(in_ready), "mean appeared without a sum")

endmodule

bind windowed_sample_averager_unit wsa_checker u_wsa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_mode   (samples.mode),
  .out_valid (means.valid),
  .out_ready (means.ready),
  .out_mean  (means.mean)
);

`default_nettype wire

// File: test/wsa_mean_checker.sv
`timescale 1ns / 1ps
// Checker for the windowed sample averager: predicts mean words and compares them.
module wsa_mean_checker #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  wsa_sample_if                       samples,
  wsa_mean_if                         means,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [wsa_pkg::PADDR_W-1:0] paddr,
  input  logic [wsa_pkg::PDATA_W-1:0] pwdata,
  input  logic [wsa_pkg::PDATA_W-1:0] prdata,
  output int                          err_count,
  output int                          pending
);

  localparam logic [wsa_pkg::PADDR_W-1:0] WIN_ADDR = {wsa_pkg::REG_WINDOW, 2'b00};

  // Shadow copy of the block's store, write position and window register
  logic [wsa_pkg::SAMPLE_W-1:0] win_store [MAX_WINDOW];
  int                           fill_pos;
  logic [wsa_pkg::WIN_W-1:0]    win_cfg;
  logic [wsa_pkg::MEAN_W-1:0]   mean_due_q [$];
  int                           fail_tally = 0;

  // Count a fault; print only the first few
  task automatic report_fault(input string what, input int unsigned want,
                              input int unsigned got);
    if (fail_tally < 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    fail_tally++;
  endtask

  // Advance the shadow state by one sample word, queue the mean it causes
  task automatic apply_word(input logic [wsa_pkg::MODE_W-1:0]   mode,
                            input logic [wsa_pkg::SAMPLE_W-1:0] smp);
    int eff;
    int total;
    eff = (win_cfg == 0) ? 1 : ((win_cfg > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg));
    // wrap the write position once it has reached the window
    if (fill_pos >= eff) fill_pos = 0;
    if (mode == wsa_pkg::MODE_BLOCK || mode == wsa_pkg::MODE_SLIDE) begin
      win_store[fill_pos] = smp;
      fill_pos++;
      if (mode == wsa_pkg::MODE_SLIDE || fill_pos == eff) begin
        total = 0;
        for (int k = 0; k < eff; k++) total += win_store[k];
        mean_due_q.push_back(wsa_pkg::MEAN_W'(total / eff));
      end
    end else begin
      // both clear codes empty the store and the position
      for (int k = 0; k < MAX_WINDOW; k++) win_store[k] = '0;
      fill_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    logic [wsa_pkg::MEAN_W-1:0] want;
    if (rst) begin
      for (int k = 0; k < MAX_WINDOW; k++) win_store[k] = '0;
      fill_pos = 0;
      win_cfg  = wsa_pkg::WIN_RESET;
      mean_due_q.delete();
    end else begin
      // compare each delivered mean word with the oldest prediction
      if (means.valid && means.ready) begin
        if (mean_due_q.size() == 0) begin
          report_fault("unexpected mean word", 0, means.mean);
        end else begin
          want = mean_due_q.pop_front();
          if (means.mean !== want) report_fault("mean", want, means.mean);
        end
      end
      if (samples.valid && samples.ready) apply_word(samples.mode, samples.sample);
      // track register writes, check readback
      if (psel && penable && pready && paddr == WIN_ADDR) begin
        if (pwrite) begin
          win_cfg = pwdata[wsa_pkg::WIN_W-1:0];
        end else if (prdata !== wsa_pkg::PDATA_W'(win_cfg)) begin
          report_fault("window readback", win_cfg, prdata);
        end
      end
    end
    pending   <= mean_due_q.size();
    err_count <= fail_tally;
  end

endmodule

// File: test/tb_windowed_sample_averager_unit.sv
`timescale 1ns / 1ps
// Testbench top for the windowed sample averager: stimulus, stalls and verdict.
module tb_windowed_sample_averager_unit;

  localparam int MAX_WINDOW   = 32;
  localparam int SAMPLE_BITS  = 16;
  localparam int ITEMS        = 1850;
  localparam int PHASES       = 12;
  localparam int DRAIN_CYCLES = 100;
  localparam int LIMIT_NS     = 2_000_000;
  localparam logic [wsa_pkg::PADDR_W-1:0] WIN_ADDR = {wsa_pkg::REG_WINDOW, 2'b00};

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [wsa_pkg::PADDR_W-1:0] paddr;
  logic [wsa_pkg::PDATA_W-1:0] pwdata;
  logic [wsa_pkg::PDATA_W-1:0] prdata;
  logic                        pready;
  int                          errs;
  int                          pending_means;
  int                          burst_left = 0;
  logic [wsa_pkg::WIN_W-1:0]   cur_win;
  int                          first_wins [7] = '{1, 32, 0, 63, 33, 2, 31};

  wsa_sample_if sample_ch ();
  wsa_mean_if   mean_ch ();

  windowed_sample_averager_unit #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .samples(sample_ch),
    .means  (mean_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  wsa_mean_checker #(
    .MAX_WINDOW(MAX_WINDOW)
  ) i_checker (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_ch),
    .means    (mean_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .err_count(errs),
    .pending  (pending_means)
  );

  // Free-running clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop
  initial begin
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: switch between stall patterns every stretch of cycles
  initial begin
    int style;
    int span;
    int tick;
    mean_ch.ready = 1'b0;
    tick = 0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 300);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (style)
          0: mean_ch.ready <= 1'b1;
          1: mean_ch.ready <= 1'($urandom_range(0, 1));
          2: mean_ch.ready <= ($urandom_range(0, 7) != 0);
          default: mean_ch.ready <= (tick % 12 == 0);
        endcase
      end
    end
  end

  // Sample value with extra weight on the extremes
  function automatic logic [wsa_pkg::SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return wsa_pkg::SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  // Offer one sample word in bursts with random gaps; hold until accepted
  task automatic push_word(input logic [wsa_pkg::MODE_W-1:0]   mode,
                           input logic [wsa_pkg::SAMPLE_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(1, 10);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    sample_ch.valid  <= 1'b1;
    sample_ch.mode   <= mode;
    sample_ch.sample <= smp;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // One APB transfer to the window register; caller drops psel after the last
  task automatic reg_access(input logic wr, input logic [wsa_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WIN_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Write the window with random upper bits, then read it back
  task automatic set_window(input logic [wsa_pkg::WIN_W-1:0] w);
    logic [wsa_pkg::PDATA_W-1:0] junk;
    junk = wsa_pkg::PDATA_W'($urandom);
    reg_access(1'b1, {junk[wsa_pkg::PDATA_W-1:wsa_pkg::WIN_W], w});
    reg_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_win = w;
  endtask

  // Drop valid, wait for every predicted mean word, then let the block go idle
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_means != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random words: mostly full block windows and sliding runs, some noise
  task automatic drive_phase(input int quota);
    int sent;
    int eff;
    int len;
    int pick;
    sent = 0;
    eff  = (cur_win == 0) ? 1 : ((cur_win > MAX_WINDOW) ? MAX_WINDOW : int'(cur_win));
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        repeat (eff) push_word(wsa_pkg::MODE_BLOCK, pick_sample());
        sent += eff;
      end else if (pick < 80) begin
        len = $urandom_range(1, 8);
        repeat (len) push_word(wsa_pkg::MODE_SLIDE, pick_sample());
        sent += len;
      end else if (pick < 92) begin
        push_word(wsa_pkg::MODE_W'($urandom_range(0, 3)), pick_sample());
        sent++;
      end else begin
        // broken block run cut short by a clear
        len = $urandom_range(1, eff);
        repeat (len) push_word(wsa_pkg::MODE_BLOCK, pick_sample());
        push_word($urandom_range(0, 1) ? wsa_pkg::MODE_CLEAR : wsa_pkg::MODE_CLEAR_ALT,
                  pick_sample());
        sent += len + 1;
      end
    end
  endtask

  initial begin
    sample_ch.valid  = 1'b0;
    sample_ch.mode   = wsa_pkg::MODE_BLOCK;
    sample_ch.sample = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst     = 1'b1;
    cur_win = wsa_pkg::WIN_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // check the reset window
    reg_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);

    // full scale and truncation at the reset window
    repeat (4) push_word(wsa_pkg::MODE_BLOCK, 16'hFFFF);
    repeat (3) push_word(wsa_pkg::MODE_BLOCK, 16'h0000);
    push_word(wsa_pkg::MODE_BLOCK, 16'h0001);
    // position wraps before the sliding word
    push_word(wsa_pkg::MODE_SLIDE, 16'hFFFF);
    // clear ignores its sample; unwritten entries count as zero
    push_word(wsa_pkg::MODE_CLEAR, 16'hFFFF);
    push_word(wsa_pkg::MODE_SLIDE, 16'h1234);
    // the spare code clears as well
    push_word(wsa_pkg::MODE_CLEAR_ALT, 16'hAAAA);
    push_word(wsa_pkg::MODE_BLOCK, 16'h5555);
    push_word(wsa_pkg::MODE_BLOCK, 16'hAAAA);
    push_word(wsa_pkg::MODE_SLIDE, 16'h8000);
    push_word(wsa_pkg::MODE_BLOCK, 16'h7FFF);

    // phases: extremes of the window first, then random sizes
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      set_window(ph < 7 ? wsa_pkg::WIN_W'(first_wins[ph])
                        : wsa_pkg::WIN_W'($urandom_range(0, wsa_pkg::WIN_MAX)));
      drive_phase(ITEMS / PHASES);
    end
    settle();

    if (errs == 0 && pending_means == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
